### sv/hds_pkg.sv
// Shared widths, register map, reset values and types for the heat diffusion stencil.
package hds_pkg;

  localparam int TEMP_W     = 32;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_COLS_W = 11;
  localparam int ALPHA_W    = 16;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;
  localparam int REG_IDX_W  = 2;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [REG_IDX_W-1:0]     reg_idx_t;

  // register indexes (byte address 4*index)
  localparam reg_idx_t REG_ROWS  = 2'd0;
  localparam reg_idx_t REG_COLS  = 2'd1;
  localparam reg_idx_t REG_ALPHA = 2'd2;

  localparam logic [ROW_W-1:0]      ROWS_RST  = 16'd1000;
  localparam logic [CFG_COLS_W-1:0] COLS_RST  = 11'd1000;
  localparam logic [ALPHA_W-1:0]    ALPHA_RST = 16'd6554;

  localparam temp_t TEMP_MAX = 32'sh7FFF_FFFF;
  localparam temp_t TEMP_MIN = 32'sh8000_0000;

  // per-item flags held in the compute stage
  typedef struct packed {
    logic has_above;  // a cell of the row above is due
    logic has_self;   // the cell itself is due (last row)
    logic interior;   // the cell above gets the full stencil
  } stage_flags_t;

endpackage

### sv/hds_ram.sv
// Generic RAM: one write port, two registered read ports.
module hds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/heat_diffusion_stencil_step.sv
// Top level: streamed five-point Jacobi heat stencil, one explicit time step.
// Throughput: one cell per cycle while the output is not stalled; on the last row each cell
//   yields two results through one output register, so the input is held until both are loaded.
// Results: the first result of a cell (the cell above it, one row late) goes through the compute
//   stage and then the output register; on the last row the cell itself follows it.
// Reset: position, valids and config registers clear to defaults; the line RAM
//   is not cleared, the first rows of each pass fill it before it is read.
module heat_diffusion_stencil_step #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [hds_pkg::TEMP_W-1:0] in_cell_temperature,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hds_pkg::ROW_W-1:0]        out_row,
  output logic [hds_pkg::OUT_COL_W-1:0]    out_column,
  output logic signed [hds_pkg::TEMP_W-1:0] out_new_temperature,
  output logic                             out_last_of_run,
  // APB-style config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hds_pkg::CFG_AW-1:0]       paddr,
  input  logic [hds_pkg::CFG_DW-1:0]       pwdata,
  output logic [hds_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
  localparam int ECW     = (CNT_W > hds_pkg::CFG_COLS_W) ? CNT_W : hds_pkg::CFG_COLS_W;
  localparam int LAP_W   = hds_pkg::TEMP_W + 3;
  localparam int PROD_W  = LAP_W + hds_pkg::ALPHA_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int TW      = hds_pkg::TEMP_W;
  localparam int RW      = hds_pkg::ROW_W;

  // ---------------------------------------------------------------------------
  // Config registers. The user must write them only while the block is idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [RW-1:0]                    grid_rows_r;
  logic [hds_pkg::CFG_COLS_W-1:0]   grid_cols_r;
  logic [hds_pkg::ALPHA_W-1:0]      alpha_r;
  logic                             cfg_wr;
  hds_pkg::reg_idx_t                cfg_idx;
  logic                             geom_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[hds_pkg::CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  // a geometry write restarts the pass at the top-left cell
  assign geom_wr = cfg_wr && (cfg_idx == hds_pkg::REG_ROWS || cfg_idx == hds_pkg::REG_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= hds_pkg::ROWS_RST;
      grid_cols_r <= hds_pkg::COLS_RST;
      alpha_r     <= hds_pkg::ALPHA_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hds_pkg::REG_ROWS:  grid_rows_r <= pwdata[RW-1:0];
        hds_pkg::REG_COLS:  grid_cols_r <= pwdata[hds_pkg::CFG_COLS_W-1:0];
        hds_pkg::REG_ALPHA: alpha_r     <= pwdata[hds_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hds_pkg::REG_ROWS:  prdata = hds_pkg::CFG_DW'(grid_rows_r);
      hds_pkg::REG_COLS:  prdata = hds_pkg::CFG_DW'(grid_cols_r);
      hds_pkg::REG_ALPHA: prdata = hds_pkg::CFG_DW'(alpha_r);
      default:            prdata = '0;
    endcase
  end

  // Effective geometry: rows at least 3, columns clamped to [3, MAX_COLUMNS].
  logic [ECW-1:0]   cols_ext;
  logic [ECW-1:0]   eff_cols;
  logic [COL_W-1:0] last_col;
  logic [RW-1:0]    last_row;

  assign cols_ext = ECW'(grid_cols_r);
  assign eff_cols = (cols_ext < ECW'(3)) ? ECW'(3) :
                    (cols_ext > ECW'(MAX_COLUMNS)) ? ECW'(MAX_COLUMNS) : cols_ext;
  assign last_col = COL_W'(eff_cols - ECW'(1));
  assign last_row = (grid_rows_r < RW'(3)) ? RW'(2) : grid_rows_r - RW'(1);

  // ---------------------------------------------------------------------------
  // Raster position and input transfer
  // ---------------------------------------------------------------------------
  logic [RW-1:0]    row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             in_xfer;

  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (!rst_n || geom_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_xfer) begin
      if (col_r == last_col) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    col_r <= col_nxt;
  end

  // ---------------------------------------------------------------------------
  // Line RAM: each word holds {older row, recent row} for one column.
  // Reads are issued from the next position, so the registered data lines up
  // with the current position; a write only hits the column just transferred,
  // never one being read.
  // ---------------------------------------------------------------------------
  logic [2*TW-1:0]    ram_a, ram_b;
  hds_pkg::temp_t     north, center, east;
  hds_pkg::temp_t     west_r;

  hds_ram #(
    .WIDTH (2 * TW),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk     (clk),
    .we      (in_xfer),
    .waddr   (col_r),
    .wdata   ({center, in_cell_temperature}),
    .raddr_a (col_nxt),
    .rdata_a (ram_a),
    .raddr_b (col_nxt + COL_W'(1)),
    .rdata_b (ram_b)
  );

  assign north  = ram_a[2*TW-1:TW];  // two rows up from the incoming cell
  assign center = ram_a[TW-1:0];     // cell above the incoming cell
  assign east   = ram_b[TW-1:0];     // right neighbor of center

  // the previous center is the west neighbor of this one
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      west_r <= center;
    end
  end

  // ---------------------------------------------------------------------------
  // Compute stage: holds one cell and its neighborhood, emits up to two results
  // ---------------------------------------------------------------------------
  hds_pkg::stage_flags_t s1_flags_r, s1_flags_in;
  hds_pkg::temp_t        s1_north_r, s1_center_r, s1_west_r, s1_east_r, s1_south_r;
  logic [RW-1:0]         s1_row_r;
  logic [COL_W-1:0]      s1_col_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_phase_r, s1_phase_nxt;
  logic                  sel_above, res_last, out_ld, s1_done;

  assign s1_flags_in.has_above = (row_r != '0);
  assign s1_flags_in.has_self  = (row_r == last_row);
  assign s1_flags_in.interior  = (row_r >= RW'(2)) && (col_r != '0) && (col_r != last_col);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_flags_r  <= s1_flags_in;
      s1_north_r  <= north;
      s1_center_r <= center;
      s1_west_r   <= west_r;
      s1_east_r   <= east;
      s1_south_r  <= in_cell_temperature;
      s1_row_r    <= row_r;
      s1_col_r    <= col_r;
    end
  end

  // result order per cell: cell above first, then the cell itself
  assign sel_above = s1_flags_r.has_above && !s1_phase_r;
  assign res_last  = !sel_above || !s1_flags_r.has_self;
  assign out_ld    = s1_valid_r && (!out_valid || !out_stall);
  assign s1_done   = out_ld && res_last;
  assign in_stall  = s1_valid_r && !s1_done;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_phase_nxt = s1_phase_r;
    if (s1_done) begin
      s1_valid_nxt = 1'b0;
      s1_phase_nxt = 1'b0;
    end else if (out_ld) begin
      s1_phase_nxt = 1'b1;
    end
    // first row cells cause nothing and never occupy the stage
    if (in_xfer) begin
      s1_valid_nxt = s1_flags_in.has_above || s1_flags_in.has_self;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_phase_r <= s1_phase_nxt;
    end
  end

  // Stencil: center + floor(lap * alpha / 2^FRACTION_BITS), saturated.
  logic signed [LAP_W-1:0]  lap;
  logic signed [PROD_W-1:0] prod, prod_sh;
  logic signed [SUM_W-1:0]  sum;
  logic                     sum_fits;
  hds_pkg::temp_t           stencil_val, res_temp;
  logic [RW-1:0]            res_row;

  assign lap      = LAP_W'(s1_north_r) + LAP_W'(s1_south_r) + LAP_W'(s1_west_r)
                  + LAP_W'(s1_east_r) - (LAP_W'(s1_center_r) <<< 2);
  assign prod     = lap * $signed({1'b0, alpha_r});
  assign prod_sh  = prod >>> FRACTION_BITS;
  assign sum      = SUM_W'(prod_sh) + SUM_W'(s1_center_r);
  assign sum_fits = (&sum[SUM_W-1:TW-1]) || !(|sum[SUM_W-1:TW-1]);
  assign stencil_val = sum_fits ? sum[TW-1:0] :
                       (sum[SUM_W-1] ? hds_pkg::TEMP_MIN : hds_pkg::TEMP_MAX);

  assign res_temp = sel_above ? (s1_flags_r.interior ? stencil_val : s1_center_r)
                              : s1_south_r;
  assign res_row  = sel_above ? s1_row_r - RW'(1) : s1_row_r;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_row             <= res_row;
      out_column          <= hds_pkg::OUT_COL_W'(s1_col_r);
      out_new_temperature <= res_temp;
      out_last_of_run     <= res_last;
    end
  end

endmodule

### sv/hds_checker.sv
// Port-level checker for the heat diffusion stencil, bound to the top level.
module hds_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [hds_pkg::ROW_W-1:0]        out_row,
  input logic [hds_pkg::OUT_COL_W-1:0]    out_column,
  input logic signed [hds_pkg::TEMP_W-1:0] out_new_temperature,
  input logic                             out_last_of_run
);

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_column)
      && $stable(out_new_temperature) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // the cell above is followed at once by the cell itself, one row down
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_valid && out_last_of_run
      && out_row == $past(out_row) + hds_pkg::ROW_W'(1)
      && out_column == $past(out_column))
    else $error("second result of a last-row cell missing or misplaced");

  // the input is only held back while a result is shown or being formed
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_valid |=> out_valid)
    else $error("input stalled with no result under way");

endmodule

bind heat_diffusion_stencil_step hds_checker u_hds_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_row             (out_row),
  .out_column          (out_column),
  .out_new_temperature (out_new_temperature),
  .out_last_of_run     (out_last_of_run)
);

### tb/tb_heat_diffusion_stencil_step.sv
// Testbench for the streamed heat stencil: random grids, stalls and register writes vs a predictor.
`timescale 1ns / 1ps

import hds_pkg::*;

typedef struct {
  logic [ROW_W-1:0]     row;
  logic [OUT_COL_W-1:0] column;
  temp_t                temp;
  logic                 last;
} cell_result_t;

// Tracks grid position and the two line buffers, predicts emitted cells.
class stencil_tracker;
  localparam int MAX_COLS = 1024;
  localparam int FRAC     = 16;

  int           rows_reg;
  int           cols_reg;
  int           alpha_reg;
  int           row_pos;
  int           col_pos;
  temp_t        recent [MAX_COLS];
  temp_t        older  [MAX_COLS];
  cell_result_t due_cells [$];
  int           errors;

  function new();
    rows_reg  = ROWS_RST;
    cols_reg  = COLS_RST;
    alpha_reg = ALPHA_RST;
    row_pos   = 0;
    col_pos   = 0;
    errors    = 0;
    foreach (recent[i]) begin
      recent[i] = '0;
      older[i]  = '0;
    end
  endfunction

  function int rows_eff();
    return (rows_reg < 3) ? 3 : rows_reg;
  endfunction

  function int cols_eff();
    if (cols_reg < 3) return 3;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function int cells_to_pass_end();
    return rows_eff() * cols_eff() - (row_pos * cols_eff() + col_pos);
  endfunction

  function int pending();
    return due_cells.size();
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  function void write_reg(reg_idx_t idx, logic [CFG_DW-1:0] data);
    case (idx)
      REG_ROWS: begin
        rows_reg = data[ROW_W-1:0];
        row_pos  = 0;
        col_pos  = 0;
      end
      REG_COLS: begin
        cols_reg = data[CFG_COLS_W-1:0];
        row_pos  = 0;
        col_pos  = 0;
      end
      REG_ALPHA: alpha_reg = data[ALPHA_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [CFG_DW-1:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_ROWS:  return CFG_DW'(rows_reg);
      REG_COLS:  return CFG_DW'(cols_reg);
      REG_ALPHA: return CFG_DW'(alpha_reg);
      default:   return '0;
    endcase
  endfunction

  // c + floor(lap * alpha / 2^FRAC), saturated to 32 bits
  function temp_t diffused(temp_t center, temp_t up, temp_t down, temp_t left, temp_t right);
    longint lap;
    longint gain;
    longint v;
    gain = alpha_reg;
    lap  = longint'(up) + longint'(down) + longint'(left) + longint'(right)
         - 4 * longint'(center);
    v    = longint'(center) + ((lap * gain) >>> FRAC);
    if (v > longint'(TEMP_MAX)) v = longint'(TEMP_MAX);
    if (v < longint'(TEMP_MIN)) v = longint'(TEMP_MIN);
    return temp_t'(v);
  endfunction

  function void note_cell(temp_t cur);
    int           r;
    int           c;
    int           rows;
    int           cols;
    cell_result_t above;
    cell_result_t self;
    rows = rows_eff();
    cols = cols_eff();
    r    = row_pos;
    c    = col_pos;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    // the cell above is complete once the one below it arrives
    if (r >= 1) begin
      above.row    = ROW_W'(r - 1);
      above.column = OUT_COL_W'(c);
      above.temp   = recent[c];
      above.last   = (r != rows - 1);
      if (r >= 2 && c >= 1 && c + 1 < cols)
        above.temp = diffused(recent[c], older[c], cur, older[c-1], recent[c+1]);
      due_cells.push_back(above);
    end
    older[c]  = recent[c];
    recent[c] = cur;
    // last row: the cell itself leaves unchanged
    if (r == rows - 1) begin
      self.row    = ROW_W'(r);
      self.column = OUT_COL_W'(c);
      self.temp   = cur;
      self.last   = 1'b1;
      due_cells.push_back(self);
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endfunction

  function void check_result(logic [ROW_W-1:0] row, logic [OUT_COL_W-1:0] column,
                             temp_t temp, logic last);
    cell_result_t want;
    if (due_cells.size() == 0) begin
      flag($sformatf("unexpected cell row %0d col %0d temp %0d last %0b",
                     row, column, temp, last));
      return;
    end
    want = due_cells.pop_front();
    if (want.row !== row || want.column !== column || want.temp !== temp ||
        want.last !== last)
      flag($sformatf("expected row %0d col %0d temp %0d last %0b, got row %0d col %0d temp %0d last %0b",
                     want.row, want.column, want.temp, want.last,
                     row, column, temp, last));
  endfunction
endclass

module tb_heat_diffusion_stencil_step;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 5;
  localparam int MAX_COLS      = 1024;
  localparam int FRAC_BITS     = 16;
  localparam int SETTLE_CYCLES = 4;     // margin after the last predicted result in settle()
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int IDLE_MAX      = 16;
  localparam int RANDOM_ITEMS  = 100;
  localparam int MIN_PHASES    = 4;
  localparam int LIMIT_CYCLES  = 1500000;

  // unmapped register slot, writes to it must be ignored
  localparam reg_idx_t REG_SPARE = 2'd3;

  typedef enum int {CELLS_ANY, CELLS_MILD, CELLS_EXTREME, CELLS_MIXED} cell_mix_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  temp_t                 in_cell_temperature;
  logic                  out_valid;
  logic                  out_stall;
  logic [ROW_W-1:0]      out_row;
  logic [OUT_COL_W-1:0]  out_column;
  temp_t                 out_new_temperature;
  logic                  out_last_of_run;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_AW-1:0]     paddr;
  logic [CFG_DW-1:0]     pwdata;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  stencil_tracker tracker = new();

  int in_gap_max  = 0;   // sender idle cycles per item, upper bound
  int out_gap_max = 0;   // receiver stall cycles per result, upper bound
  bit hold_req    = 1'b0;

  heat_diffusion_stencil_step #(
    .MAX_COLUMNS   (MAX_COLS),
    .FRACTION_BITS (FRAC_BITS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cell_temperature (in_cell_temperature),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_row             (out_row),
    .out_column          (out_column),
    .out_new_temperature (out_new_temperature),
    .out_last_of_run     (out_last_of_run),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // One APB transfer: setup cycle, then access until pready. Afterwards psel is low at a clock
  // edge, so back-to-back calls never touch psel twice in one step.
  task automatic cfg_access(reg_idx_t idx, logic wr, logic [CFG_DW-1:0] data,
                            output logic [CFG_DW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write, then read back mapped registers; only legal while the block is idle.
  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] data);
    logic [CFG_DW-1:0] rd;
    cfg_access(idx, 1'b1, data, rd);
    tracker.write_reg(idx, data);
    if (idx != REG_SPARE) begin
      cfg_access(idx, 1'b0, '0, rd);
      if (rd !== tracker.reg_value(idx))
        tracker.flag($sformatf("register %0d read %0h, expected %0h",
                               idx, rd, tracker.reg_value(idx)));
    end
  endtask

  // Random upper bits ride along on pwdata; the registers keep only their width.
  function automatic logic [CFG_DW-1:0] with_noise(int value, int width);
    logic [CFG_DW-1:0] noise;
    noise = $urandom();
    return (noise << width) | CFG_DW'(value);
  endfunction

  // Offer one cell after a random gap and hold it until the transfer.
  task automatic send_cell(temp_t t);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cell_temperature <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_cell(t);
  endtask

  function automatic temp_t pick_cell(cell_mix_t mix);
    cell_mix_t m;
    m = mix;
    if (m == CELLS_MIXED) m = cell_mix_t'($urandom_range(0, 2));
    case (m)
      CELLS_MILD:
        // within +-100.0 degrees, so the arithmetic shift rounds both ways
        return temp_t'(int'($urandom_range(0, 200 * 65536)) - 100 * 65536);
      CELLS_EXTREME:
        case ($urandom_range(0, 4))
          0:       return TEMP_MAX;
          1:       return TEMP_MIN;
          2:       return '0;
          3:       return '1;
          default: return temp_t'(1);
        endcase
      default:
        return temp_t'($urandom());
    endcase
  endfunction

  task automatic send_cells(int n, cell_mix_t mix);
    for (int i = 0; i < n; i++) send_cell(pick_cell(mix));
  endtask

  // Drop valid and wait until every predicted cell has come out, plus a few cycles
  // because first-row cells leave nothing to wait for.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: check every transfer, then stall for a drawn number of cycles.
  // A hold request stalls it for a long stretch so the block backs up.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_result(out_row, out_column, out_new_temperature, out_last_of_run);
        stall_left = $urandom_range(0, out_gap_max);
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed saturation grids, one extra-wide partial pass, then random phases.
  initial begin
    int        rand_items;
    int        phase;
    int        n;
    int        half;
    bit        force_geom;
    cell_mix_t mix;

    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_cell_temperature = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // undersized geometry acts as 3x3, only the center is interior
    write_reg(REG_ROWS, 0);
    write_reg(REG_COLS, 2);
    write_reg(REG_ALPHA, 32'h0000_FFFF);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    // cold center among hot neighbors saturates high
    for (int i = 0; i < 9; i++) send_cell((i == 4) ? TEMP_MIN : TEMP_MAX);
    // second pass after wrap, hot center among cold ones saturates low
    for (int i = 0; i < 9; i++) send_cell((i == 4) ? TEMP_MAX : TEMP_MIN);
    settle();

    // widest line: columns clamp to the buffer depth, tallest grid, one row and a bit
    in_gap_max  = 1;
    out_gap_max = 1;
    write_reg(REG_ROWS, 32'h0000_FFFF);
    write_reg(REG_COLS, 32'h0000_07FF);
    write_reg(REG_ALPHA, with_noise($urandom_range(0, 65535), ALPHA_W));
    send_cells(MAX_COLS + 5, CELLS_ANY);
    force_geom = 1'b1;

    rand_items = 0;
    phase      = 0;
    while (rand_items < RANDOM_ITEMS || phase < MIN_PHASES) begin
      settle();
      case ($urandom_range(0, 3))
        0:       in_gap_max = 0;
        1:       in_gap_max = 2;
        default: in_gap_max = IDLE_MAX;
      endcase
      case ($urandom_range(0, 3))
        0:       out_gap_max = 0;
        1:       out_gap_max = 2;
        default: out_gap_max = IDLE_MAX;
      endcase

      // geometry writes restart the pass; skipping them continues where the last phase stopped
      if (force_geom || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(0, 2);
          1:       n = $urandom_range(9, 16);
          default: n = $urandom_range(3, 8);
        endcase
        write_reg(REG_ROWS, with_noise(n, ROW_W));
        case ($urandom_range(0, 9))
          0:       n = $urandom_range(0, 2);
          1:       n = $urandom_range(13, 40);
          default: n = $urandom_range(3, 12);
        endcase
        write_reg(REG_COLS, with_noise(n, CFG_COLS_W));
        force_geom = 1'b0;
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       n = 0;
          1:       n = 65535;
          default: n = $urandom_range(0, 65535);
        endcase
        write_reg(REG_ALPHA, with_noise(n, ALPHA_W));
      end

      mix = cell_mix_t'($urandom_range(0, 3));
      n   = tracker.cells_to_pass_end();
      case ($urandom_range(0, 5))
        0: if (n > 1) n = $urandom_range(1, n - 1);   // stop mid-pass
        1: n = n + tracker.rows_eff() * tracker.cols_eff();
        default: ;
      endcase

      if (phase == 1) begin
        // block fills and stalls its input while results are held off;
        // two rows and a bit always reach cells that cause results
        if (n < 2 * tracker.cols_eff() + 2) n = 2 * tracker.cols_eff() + 2;
        in_gap_max = 0;
        hold_req   = 1'b1;
        send_cells(n, mix);
      end else if (phase == 3 && n > 1) begin
        // sender waits for every outstanding result midway through the pass
        half = n / 2;
        send_cells(half, mix);
        settle();
        send_cells(n - half, mix);
      end else begin
        send_cells(n, mix);
      end
      rand_items += n;
      phase++;
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS heat_diffusion_stencil_step");
    end else begin
      $display("FAIL heat_diffusion_stencil_step");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL heat_diffusion_stencil_step");
    $finish;
  end

endmodule

### heat_diffusion_stencil_step.f
sv/hds_pkg.sv
sv/hds_ram.sv
sv/heat_diffusion_stencil_step.sv
sv/hds_checker.sv
tb/tb_heat_diffusion_stencil_step.sv
